[hw/rtl/ppts_pkg.sv]
// shared types and constants for the periodic priority task scheduler
// no dependencies
package ppts_pkg;

  localparam int TaskSlots  = 16;
  localparam int PrioLevels = 8;
  localparam int IdWidth    = 4;
  localparam int UsPerMs    = 1000;

  typedef enum logic [2:0] {
    KIND_CREATE   = 3'd0,
    KIND_DELETE   = 3'd1,
    KIND_SUSPEND  = 3'd2,
    KIND_RESUME   = 3'd3,
    KIND_SCHEDULE = 3'd4,
    KIND_COMPLETE = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_READY      = 3'd0,
    ST_RUNNING    = 3'd1,
    ST_BLOCKED    = 3'd2,
    ST_SUSPENDED  = 3'd3,
    ST_TERMINATED = 3'd4
  } task_state_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_MULT,
    FSM_UPDATE,
    FSM_OUT
  } fsm_t;

  // per-slot view handed to the compare unit
  typedef struct packed {
    logic        eligible;
    logic        periodic;
    logic [19:0] period;
    logic [31:0] last_run;
  } cand_t;

endpackage

[hw/rtl/ppts_due_unit.sv]
// shared compare unit: due test of one slot per cycle, and deadline compare
// depends on ppts_pkg
module ppts_due_unit (
  input  ppts_pkg::cand_t cand,
  input  logic [31:0]     now_ms,
  input  logic [41:0]     budget_us,
  input  logic [31:0]     exec_us,
  output logic            due,
  output logic            over
);
  logic [31:0] elapsed;

  // wrapped elapsed time against period
  assign elapsed = now_ms - cand.last_run;
  assign due     = cand.eligible && (!cand.periodic || elapsed >= {12'd0, cand.period});

  // exec time against period in microseconds
  assign over = {10'd0, exec_us} > budget_us;
endmodule

[hw/rtl/periodic_priority_task_scheduler.sv]
// top level of the periodic priority task scheduler: task table, sequencer
// depends on ppts_pkg and ppts_due_unit
//
// channel  dir  handshake           payload
// s_axis   in   s_axis_t{valid,ready} tdata
// m_axis   out  m_axis_t{valid,ready} tdata
//
// a schedule item scans slots 1 up to the last used slot, one slot scanned per
// cycle through the shared compare unit, then updates and outputs; a completion
// passes through SCAN, MULT, UPDATE and OUT, other items through SCAN, UPDATE
// and OUT
// the block takes one word at a time; a held result stalls the next item
// reset is synchronous and restores the idle task in slot 0
module periodic_priority_task_scheduler #(
  parameter int TASK_SLOTS  = ppts_pkg::TaskSlots,
  parameter int PRIO_LEVELS = ppts_pkg::PrioLevels
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // kind[2:0], task_id[6:3], priority_req[9:7], new_period[29:10],
  // periodic[30], now_ms[62:31], exec_us[94:63], zero fill to 96
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[0], chosen_id[4:1], found[5], deadline_missed[6], zero fill to 8
  output logic [7:0]  m_axis_tdata
);
  localparam int SW = $clog2(TASK_SLOTS);
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [2:0] PMAX = (PRIO_LEVELS > 8) ? 3'd7 : 3'(PRIO_LEVELS - 1);

  // task table
  ppts_pkg::task_state_t slot_state [TASK_SLOTS];
  logic [2:0]  slot_priority    [TASK_SLOTS];
  logic [19:0] slot_period      [TASK_SLOTS];
  logic [31:0] slot_last_run    [TASK_SLOTS];
  logic        slot_is_periodic [TASK_SLOTS];
  logic [31:0] slot_run_count   [TASK_SLOTS];
  logic [31:0] slot_exec_total  [TASK_SLOTS];
  logic [31:0] slot_miss_count  [TASK_SLOTS];
  logic [CW-1:0] used_slots;
  logic [4:0]  live_tasks;
  logic [31:0] switch_total, miss_total, idle_total_us;

  // latched item
  logic [2:0]  kind;
  logic [3:0]  task_id;
  logic [2:0]  prio;
  logic [19:0] new_period;
  logic        periodic;
  logic [31:0] now_ms, exec_us;

  ppts_pkg::fsm_t state, state_next;
  logic [CW-1:0] scan_idx;
  logic [2:0]    best;
  logic [SW-1:0] pick;
  logic [41:0]   budget_us;
  logic          status, found, missed;
  logic [3:0]    chosen;

  logic [SW-1:0]   tid;
  logic            id_ok;
  ppts_pkg::cand_t cand;
  logic            due, over;

  assign tid   = SW'(task_id);
  assign id_ok = ({{(CW > 4 ? CW-4 : 0){1'b0}}, task_id} < used_slots)
                 && (32'(task_id) < TASK_SLOTS)
                 && (slot_state[tid] != ppts_pkg::ST_TERMINATED);

  // candidate for the compare unit
  always_comb begin
    logic [SW-1:0] ci;
    ci = (state == ppts_pkg::FSM_SCAN) ? scan_idx[SW-1:0] : tid;
    cand.eligible = (slot_state[ci] == ppts_pkg::ST_READY)
                    || (slot_state[ci] == ppts_pkg::ST_RUNNING);
    cand.periodic = slot_is_periodic[ci];
    cand.period   = slot_period[ci];
    cand.last_run = slot_last_run[ci];
  end

  ppts_due_unit u_due (
    .cand(cand), .now_ms(now_ms), .budget_us(budget_us), .exec_us(exec_us),
    .due(due), .over(over)
  );

  function automatic logic [31:0] sat_inc(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ppts_pkg::FSM_IDLE: if (s_axis_tvalid) state_next = ppts_pkg::FSM_SCAN;
      ppts_pkg::FSM_SCAN: begin
        if (kind == ppts_pkg::KIND_SCHEDULE) begin
          if (scan_idx >= used_slots || 32'(scan_idx) >= TASK_SLOTS - 1)
            state_next = ppts_pkg::FSM_UPDATE;
        end else if (kind == ppts_pkg::KIND_COMPLETE) begin
          state_next = ppts_pkg::FSM_MULT;
        end else begin
          state_next = ppts_pkg::FSM_UPDATE;
        end
      end
      ppts_pkg::FSM_MULT:   state_next = ppts_pkg::FSM_UPDATE;
      ppts_pkg::FSM_UPDATE: state_next = ppts_pkg::FSM_OUT;
      ppts_pkg::FSM_OUT:    if (m_axis_tready) state_next = ppts_pkg::FSM_IDLE;
      default:              state_next = ppts_pkg::FSM_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = (state == ppts_pkg::FSM_IDLE);
    m_axis_tvalid = (state == ppts_pkg::FSM_OUT);
    m_axis_tdata  = {1'b0, missed, found, chosen, status};
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ppts_pkg::FSM_IDLE;
    else     state <= state_next;
  end

  // datapath and table updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        slot_state[i]       <= ppts_pkg::ST_READY;
        slot_priority[i]    <= '0;
        slot_period[i]      <= (i == 0) ? 20'd10 : 20'd0;
        slot_last_run[i]    <= '0;
        slot_is_periodic[i] <= (i == 0);
        slot_run_count[i]   <= '0;
        slot_exec_total[i]  <= '0;
        slot_miss_count[i]  <= '0;
      end
      used_slots    <= CW'(1);
      live_tasks    <= '0;
      switch_total  <= '0;
      miss_total    <= '0;
      idle_total_us <= '0;
    end else begin
      unique case (state)
        ppts_pkg::FSM_IDLE: begin
          if (s_axis_tvalid) begin
            kind       <= s_axis_tdata[2:0];
            task_id    <= s_axis_tdata[6:3];
            prio       <= s_axis_tdata[9:7];
            new_period <= s_axis_tdata[29:10];
            periodic   <= s_axis_tdata[30];
            now_ms     <= s_axis_tdata[62:31];
            exec_us    <= s_axis_tdata[94:63];
            scan_idx   <= CW'(1);
            best       <= '0;
            pick       <= '0;
            status     <= 1'b0;
            found      <= 1'b0;
            missed     <= 1'b0;
            chosen     <= '0;
          end
        end
        ppts_pkg::FSM_SCAN: begin
          // one slot per cycle, strict greater keeps the lowest slot on ties
          if (scan_idx < used_slots && due && slot_priority[scan_idx[SW-1:0]] > best) begin
            best <= slot_priority[scan_idx[SW-1:0]];
            pick <= scan_idx[SW-1:0];
          end
          scan_idx <= scan_idx + CW'(1);
          budget_us <= 42'(slot_period[tid]) * 42'(ppts_pkg::UsPerMs);
        end
        ppts_pkg::FSM_MULT: ;
        ppts_pkg::FSM_UPDATE: begin
          unique case (kind)
            ppts_pkg::KIND_CREATE: begin
              if (32'(used_slots) >= TASK_SLOTS) status <= 1'b1;
              else begin
                slot_state[used_slots[SW-1:0]]       <= ppts_pkg::ST_READY;
                slot_priority[used_slots[SW-1:0]]    <= (prio > PMAX) ? PMAX : prio;
                slot_period[used_slots[SW-1:0]]      <= new_period;
                slot_last_run[used_slots[SW-1:0]]    <= now_ms;
                slot_is_periodic[used_slots[SW-1:0]] <= periodic;
                slot_run_count[used_slots[SW-1:0]]   <= '0;
                slot_exec_total[used_slots[SW-1:0]]  <= '0;
                slot_miss_count[used_slots[SW-1:0]]  <= '0;
                used_slots <= used_slots + CW'(1);
                live_tasks <= live_tasks + 5'd1;
                chosen     <= 4'(used_slots);
              end
            end
            ppts_pkg::KIND_DELETE: begin
              if (task_id == 4'd0 || !id_ok) status <= 1'b1;
              else begin
                slot_state[tid] <= ppts_pkg::ST_TERMINATED;
                if (live_tasks != 5'd0) live_tasks <= live_tasks - 5'd1;
              end
            end
            ppts_pkg::KIND_SUSPEND, ppts_pkg::KIND_RESUME: begin
              if (!id_ok) status <= 1'b1;
              else slot_state[tid] <= (kind == ppts_pkg::KIND_SUSPEND)
                                      ? ppts_pkg::ST_SUSPENDED : ppts_pkg::ST_READY;
            end
            ppts_pkg::KIND_SCHEDULE: begin
              if (pick != '0) begin
                slot_state[pick]     <= ppts_pkg::ST_READY;
                slot_last_run[pick]  <= now_ms;
                slot_run_count[pick] <= sat_inc(slot_run_count[pick], 32'd1);
                switch_total <= sat_inc(switch_total, 32'd1);
                found  <= 1'b1;
                chosen <= 4'(pick);
              end else begin
                idle_total_us <= sat_inc(idle_total_us, 32'(ppts_pkg::UsPerMs));
              end
            end
            ppts_pkg::KIND_COMPLETE: begin
              if (task_id == 4'd0 || !id_ok) status <= 1'b1;
              else begin
                slot_exec_total[tid] <= sat_inc(slot_exec_total[tid], exec_us);
                if (slot_is_periodic[tid] && over) begin
                  slot_miss_count[tid] <= sat_inc(slot_miss_count[tid], 32'd1);
                  miss_total <= sat_inc(miss_total, 32'd1);
                  missed <= 1'b1;
                end
              end
            end
            default: status <= 1'b1;
          endcase
        end
        ppts_pkg::FSM_OUT: ;
        default: ;
      endcase
    end
  end

  // a result is never shown while an item is being taken
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready during output");
  // result holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  // slot 0 stays allocated
  a_used: assert property (@(posedge clk) disable iff (rst)
    used_slots != '0) else $error("used slots cleared");
  // found only from schedule with a real slot
  a_found: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && found |-> chosen != 4'd0) else $error("idle chosen");
endmodule
